// ===== hdl/itsc_pkg.sv =====
// Shared constants and types for the itemset support counter.
package itsc_pkg;

  // Default store depth and item mask width.
  localparam int DEF_MAX_TXNS  = 4096;
  localparam int DEF_ITEM_BITS = 64;

  // Fixed port widths.
  localparam int KIND_W     = 2;
  localparam int MASK_W     = 64;
  localparam int OUT_CNT_W  = 13;

  // Item mask bits checked by one match cell.
  localparam int CELL_SLICE_W = 8;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Control handed from one match cell to the next.
  typedef struct packed {
    logic valid;
    logic match;
  } cell_link_t;

endpackage

// ===== hdl/itsc_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module itsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/itsc_cell.sv =====
// One match cell: checks one slice of a stored transaction against the query.
module itsc_cell import itsc_pkg::*; #(
  parameter int WORD_W  = 64,
  parameter int SLICE_W = CELL_SLICE_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic [SLICE_W-1:0] need_i,
  input  cell_link_t         link_i,
  input  logic [WORD_W-1:0]  word_i,
  output cell_link_t         link_o,
  output logic [WORD_W-1:0]  word_o
);

  logic [SLICE_W-1:0] need_r;
  cell_link_t         link_r, link_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;

  // The cell's slice of the query is loaded when a query starts.
  always_ff @(posedge clk) begin
    if (load) begin
      need_r <= need_i;
    end
  end

  // A word matches so far if every earlier slice and this slice cover the query.
  always_comb begin
    link_nxt.valid = link_i.valid;
    link_nxt.match = link_i.match && ((word_i[SLICE_W-1:0] & need_r) == need_r);
    word_nxt       = word_i >> SLICE_W;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  // The remaining slices move on to the next cell.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign link_o = link_r;
  assign word_o = word_r;

endmodule

// ===== hdl/itemset_support_counter.sv =====
// Itemset support counter: transaction store with a chain of match cells.
// Clear, add and unused kinds give their result the cycle after the item, busy stays low.
// A query with seen items and a nonempty store makes one RAM read per cycle over the stored
// transactions, then waits for the drain of the match cell chain.
// Results are one-cycle strobes; the receiver cannot stall. Synchronous reset empties the
// store and the seen mask; store contents are not cleared.
module itemset_support_counter import itsc_pkg::*; #(
  parameter int MAX_TXNS  = DEF_MAX_TXNS,
  parameter int ITEM_BITS = DEF_ITEM_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [MASK_W-1:0]    in_item_mask,
  output logic                 out_valid,
  output logic [OUT_CNT_W-1:0] out_support_count,
  output logic [OUT_CNT_W-1:0] out_txn_total,
  output logic                 out_status
);

  localparam int ADDR_W    = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
  localparam int FILL_W    = $clog2(MAX_TXNS + 1);
  localparam int NUM_CELLS = (ITEM_BITS + CELL_SLICE_W - 1) / CELL_SLICE_W;
  localparam int PAD_W     = NUM_CELLS * CELL_SLICE_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [ITEM_BITS-1:0] seen_r, seen_nxt;
  logic [ADDR_W-1:0]    scan_r, scan_nxt;
  logic [FILL_W-1:0]    count_r, count_nxt;
  logic                 rd_valid_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_CNT_W-1:0] out_sup_r, out_sup_nxt;
  logic [OUT_CNT_W-1:0] out_tot_r, out_tot_nxt;
  logic                 out_status_r, out_status_nxt;

  logic [ITEM_BITS-1:0] mask;
  logic [ITEM_BITS-1:0] need;
  logic [PAD_W-1:0]     need_pad;
  logic                 full;
  logic                 last_read;
  logic                 rd_en;
  logic                 wr_en;
  logic                 load;
  logic                 pipe_busy;
  logic [ITEM_BITS-1:0] rd_data;

  cell_link_t           link [NUM_CELLS+1];
  logic [PAD_W-1:0]     word [NUM_CELLS+1];

  // Item fields and derived query mask.
  assign mask      = in_item_mask[ITEM_BITS-1:0];
  assign need      = mask & seen_r;
  assign need_pad  = PAD_W'(need);
  assign full      = (fill_r == FILL_W'(MAX_TXNS));
  assign last_read = ((FILL_W'(scan_r) + FILL_W'(1)) == fill_r);
  assign rd_en     = (state_r == ST_SCAN);
  assign busy      = (state_r != ST_IDLE);

  // Transaction store.
  itsc_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (MAX_TXNS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_r[ADDR_W-1:0]),
    .wr_data(mask),
    .rd_addr(scan_r),
    .rd_data(rd_data)
  );

  // Words leaving the store enter the chain of match cells.
  assign link[0].valid = rd_valid_r;
  assign link[0].match = 1'b1;
  assign word[0]       = PAD_W'(rd_data);

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    itsc_cell #(
      .WORD_W (PAD_W),
      .SLICE_W(CELL_SLICE_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (load),
      .need_i(need_pad[k*CELL_SLICE_W +: CELL_SLICE_W]),
      .link_i(link[k]),
      .word_i(word[k]),
      .link_o(link[k+1]),
      .word_o(word[k+1])
    );
  end

  // Any word still in flight between the store and the counter.
  always_comb begin
    pipe_busy = rd_valid_r;
    for (int k = 1; k <= NUM_CELLS; k++) begin
      pipe_busy = pipe_busy | link[k].valid;
    end
  end

  // Sequencer for the item kinds and the query scan.
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    seen_nxt       = seen_r;
    scan_nxt       = scan_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_sup_nxt    = out_sup_r;
    out_tot_nxt    = out_tot_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    load           = 1'b0;

    if (link[NUM_CELLS].valid && link[NUM_CELLS].match) begin
      count_nxt = count_r + FILL_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_sup_nxt    = '0;
          out_status_nxt = STATUS_OK;
          out_tot_nxt    = OUT_CNT_W'(fill_r);
          case (in_kind)
            KIND_CLEAR: begin
              fill_nxt      = '0;
              seen_nxt      = '0;
              out_tot_nxt   = '0;
              out_valid_nxt = 1'b1;
            end
            KIND_ADD: begin
              if (full) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                wr_en       = 1'b1;
                fill_nxt    = fill_r + FILL_W'(1);
                seen_nxt    = seen_r | mask;
                out_tot_nxt = OUT_CNT_W'(fill_r + FILL_W'(1));
              end
              out_valid_nxt = 1'b1;
            end
            KIND_QUERY: begin
              if ((need == '0) || (fill_r == '0)) begin
                out_valid_nxt = 1'b1;
              end else begin
                load      = 1'b1;
                scan_nxt  = '0;
                count_nxt = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + ADDR_W'(1);
        if (last_read) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          out_valid_nxt  = 1'b1;
          out_sup_nxt    = OUT_CNT_W'(count_r);
          out_tot_nxt    = OUT_CNT_W'(fill_r);
          out_status_nxt = STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      seen_r      <= '0;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      rd_valid_r  <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan address and result payload.
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    out_sup_r    <= out_sup_nxt;
    out_tot_r    <= out_tot_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_support_count = out_sup_r;
  assign out_txn_total     = out_tot_r;
  assign out_status        = out_status_r;

  // The scan never reads past the filled part of the store.
  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (FILL_W'(scan_r) < fill_r))
    else $error("scan address beyond store fill");

  // The fill count never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_TXNS))
    else $error("store fill beyond depth");

  // A new item is only taken with the match chain empty.
  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !pipe_busy)
    else $error("item accepted while words in flight");

  // The running support count never exceeds the stored transactions.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r <= fill_r))
    else $error("support count above store fill");

endmodule
